[rtl/bfmip_pkg.sv]
// Shared types and constants for the box filter mipmap generator.
package bfmip_pkg;

  localparam int MAX_LOG2_SIZE_DEF = 10;
  localparam int VALUE_BITS_DEF    = 16;

  localparam int TEXEL_W   = 16;
  localparam int LEVEL_W   = 4;
  localparam int POS_W     = 10;
  localparam int LOG2_W    = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [LOG2_W-1:0] LOG2_RESET = LOG2_W'(10);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_ADD
  } state_t;

endpackage

[rtl/bfmip_cfg_if.sv]
// Configuration write channel.
interface bfmip_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bfmip_pkg::CFG_IDX_W-1:0]  index;
  logic [bfmip_pkg::LOG2_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bfmip_in_if.sv]
// Base level texel input channel.
interface bfmip_in_if;
  logic                           valid;
  logic                           ready;
  logic [bfmip_pkg::TEXEL_W-1:0]  texel_value;
  logic                           start_of_image;

  modport source (output valid, output texel_value, output start_of_image, input ready);
  modport sink   (input valid, input texel_value, input start_of_image, output ready);
endinterface

[rtl/bfmip_out_if.sv]
// Mipmap texel result channel.
interface bfmip_out_if;
  logic                           valid;
  logic                           ready;
  logic [bfmip_pkg::LEVEL_W-1:0]  level;
  logic [bfmip_pkg::POS_W-1:0]    column;
  logic [bfmip_pkg::POS_W-1:0]    row;
  logic [bfmip_pkg::TEXEL_W-1:0]  averaged_value;
  logic                           last_of_run;

  modport source (output valid, output level, output column, output row,
                  output averaged_value, output last_of_run, input ready);
  modport sink   (input valid, input level, input column, input row,
                  input averaged_value, input last_of_run, output ready);
endinterface

[rtl/bfmip_line_buf.sv]
// Line buffer of pair sums for every level below the coarsest, one write and one registered read port.
module bfmip_line_buf #(
  parameter int MAX_LOG2_SIZE = bfmip_pkg::MAX_LOG2_SIZE_DEF,
  parameter int VALUE_BITS    = bfmip_pkg::VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [MAX_LOG2_SIZE-1:0] wr_addr,
  input  logic [VALUE_BITS:0]      wr_data,
  input  logic                     rd_en,
  input  logic [MAX_LOG2_SIZE-1:0] rd_addr,
  output logic [VALUE_BITS:0]      rd_data
);

  localparam int DEPTH = (1 << MAX_LOG2_SIZE) - 1;

  logic [VALUE_BITS:0] mem [0:DEPTH-1];
  logic [VALUE_BITS:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/box_filter_mipmap_generator.sv]
// Top level: streaming 2x2 box filter mipmap generator.
// Level 0 word: the accepted input enters ST_EMIT and is registered on out once the output slot is free.
// A new input word is accepted only in ST_IDLE, after the whole run of L words emitted for the last one
//   (with A = L - 1 line buffer reads between them), since the one shared level update /
//   averaging unit and the registered line buffer read serve one level at a time.
// Reset: sync, active low; clears level counters, pending texels and sizes (2^10 x 2^10).
//   Line buffer is not cleared; every entry is written before it is read.
module box_filter_mipmap_generator #(
  parameter int MAX_LOG2_SIZE = bfmip_pkg::MAX_LOG2_SIZE_DEF,
  parameter int VALUE_BITS    = bfmip_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bfmip_cfg_if.sink   cfg_if,
  bfmip_in_if.sink    in_if,
  bfmip_out_if.source out_if
);

  localparam int CW         = MAX_LOG2_SIZE;        // counter / line buffer index width
  localparam int LEVEL_CNT  = MAX_LOG2_SIZE + 1;
  localparam int LVL_W      = $clog2(LEVEL_CNT);
  localparam int VB         = VALUE_BITS;
  localparam int LW         = bfmip_pkg::LOG2_W;
  localparam int TW         = bfmip_pkg::TEXEL_W;
  localparam int PW         = bfmip_pkg::POS_W;
  localparam int LEVW       = bfmip_pkg::LEVEL_W;
  localparam logic [LW-1:0] MAX_LOG2 = LW'(MAX_LOG2_SIZE);

  // ---------------- configuration registers ----------------
  logic [LW-1:0] width_log2_r;
  logic [LW-1:0] height_log2_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_log2_r  <= bfmip_pkg::LOG2_RESET;
      height_log2_r <= bfmip_pkg::LOG2_RESET;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        bfmip_pkg::CFG_WIDTH_LOG2:  width_log2_r  <= cfg_if.data;
        bfmip_pkg::CFG_HEIGHT_LOG2: height_log2_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // sizes above the supported maximum clamp to it
  logic [LW-1:0] wl_sat;
  logic [LW-1:0] hl_sat;
  assign wl_sat = (width_log2_r  > MAX_LOG2) ? MAX_LOG2 : width_log2_r;
  assign hl_sat = (height_log2_r > MAX_LOG2) ? MAX_LOG2 : height_log2_r;

  // ---------------- sequencer state ----------------
  bfmip_pkg::state_t state_r, state_nxt;

  logic [LVL_W-1:0] lvl_r;       // level being placed
  logic [LVL_W-1:0] wl_r;
  logic [LVL_W-1:0] hl_r;
  logic [LVL_W-1:0] top_lvl_r;   // coarsest level
  logic [VB-1:0]    v_r;         // texel value at the current level
  logic [VB:0]      pair_r;      // pair sum waiting for the line buffer read
  logic [CW-1:0]    col_r  [LEVEL_CNT];
  logic [CW-1:0]    row_r  [LEVEL_CNT];
  logic [VB-1:0]    pend_r [LEVEL_CNT];

  logic out_valid_r;
  logic [LEVW-1:0] out_level_r;
  logic [PW-1:0]   out_column_r;
  logic [PW-1:0]   out_row_r;
  logic [TW-1:0]   out_value_r;
  logic            out_last_r;

  logic in_fire;
  logic slot_free;
  logic emit_fire;

  assign in_fire   = in_if.valid && in_if.ready;
  assign slot_free = !out_valid_r || out_if.ready;
  assign emit_fire = (state_r == bfmip_pkg::ST_EMIT) && slot_free;

  // ---------------- shared level unit ----------------
  logic [CW-1:0] col_cur, row_cur;
  logic [CW:0]   wlen, hlen;
  logic [CW-1:0] c_eff, r_eff;
  logic [CW:0]   c_inc, r_inc;
  logic          c_wrap, r_wrap;
  logic          is_top;
  logic          go_up;
  logic          wr_en;
  logic          rd_en;
  logic [VB:0]   pair;
  logic [CW:0]   full_span;
  logic [CW:0]   base_w;
  logic [CW-1:0] idx;
  logic [VB:0]   rd_data;
  logic [VB+1:0] quad_sum;

  assign col_cur = col_r[lvl_r];
  assign row_cur = row_r[lvl_r];
  assign wlen    = (CW+1)'(1) << (wl_r - lvl_r);
  assign hlen    = (CW+1)'(1) << (hl_r - lvl_r);

  // counters beyond the level size (after a size change) restart at 0
  assign c_eff  = ({1'b0, col_cur} >= wlen) ? '0 : col_cur;
  assign r_eff  = ({1'b0, row_cur} >= hlen) ? '0 : row_cur;
  assign c_inc  = {1'b0, c_eff} + (CW+1)'(1);
  assign r_inc  = {1'b0, r_eff} + (CW+1)'(1);
  assign c_wrap = (c_inc >= wlen);
  assign r_wrap = (r_inc >= hlen);

  assign is_top = (lvl_r == top_lvl_r);
  assign pair   = {1'b0, pend_r[lvl_r]} + {1'b0, v_r};

  // level l owns the line buffer entries from 2^M - 2^(M-l) upward
  assign full_span = (CW+1)'(1) << CW;
  assign base_w    = full_span - (full_span >> lvl_r);
  assign idx       = base_w[CW-1:0] + (c_eff >> 1);

  // odd column, odd row: a 2x2 block completes and the average moves up one level
  assign go_up = !is_top && c_eff[0] && r_eff[0];
  assign wr_en = emit_fire && !is_top && c_eff[0] && !r_eff[0];
  assign rd_en = emit_fire && go_up;

  assign quad_sum = {1'b0, rd_data} + {1'b0, pair_r};

  bfmip_line_buf #(
    .MAX_LOG2_SIZE (MAX_LOG2_SIZE),
    .VALUE_BITS    (VALUE_BITS)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (pair),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfmip_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = bfmip_pkg::ST_EMIT;
      end
      bfmip_pkg::ST_EMIT: begin
        if (emit_fire) state_nxt = go_up ? bfmip_pkg::ST_ADD : bfmip_pkg::ST_IDLE;
      end
      bfmip_pkg::ST_ADD: begin
        state_nxt = bfmip_pkg::ST_EMIT;
      end
      default: state_nxt = bfmip_pkg::ST_IDLE;
    endcase
  end

  // ---------------- handshake outputs ----------------
  always_comb begin
    in_if.ready = (state_r == bfmip_pkg::ST_IDLE);
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.level          = out_level_r;
  assign out_if.column         = out_column_r;
  assign out_if.row            = out_row_r;
  assign out_if.averaged_value = out_value_r;
  assign out_if.last_of_run    = out_last_r;

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfmip_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVEL_CNT; i++) begin
        col_r[i]  <= '0;
        row_r[i]  <= '0;
        pend_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire && in_if.start_of_image) begin
        for (int i = 0; i < LEVEL_CNT; i++) begin
          col_r[i] <= '0;
          row_r[i] <= '0;
        end
      end
      if (emit_fire) begin
        col_r[lvl_r] <= c_wrap ? '0 : c_inc[CW-1:0];
        row_r[lvl_r] <= !c_wrap ? r_eff : (r_wrap ? '0 : r_inc[CW-1:0]);
        // the coarsest level never pairs, so its left texel is not kept
        if (!is_top && !c_eff[0]) begin
          pend_r[lvl_r] <= v_r;
        end
      end
    end
  end

  // ---------------- payload registers ----------------
  logic [TW+VB-1:0]   in_ext;
  logic [VB+TW-1:0]   v_ext;
  logic [LVL_W+LEVW-1:0] lvl_ext;
  logic [CW+PW-1:0]   c_ext, r_ext;

  assign in_ext  = {{VB{1'b0}}, in_if.texel_value};
  assign v_ext   = {{TW{1'b0}}, v_r};
  assign lvl_ext = {{LEVW{1'b0}}, lvl_r};
  assign c_ext   = {{PW{1'b0}}, c_eff};
  assign r_ext   = {{PW{1'b0}}, r_eff};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      v_r       <= in_ext[VB-1:0];
      lvl_r     <= '0;
      wl_r      <= wl_sat[LVL_W-1:0];
      hl_r      <= hl_sat[LVL_W-1:0];
      top_lvl_r <= (wl_sat < hl_sat) ? wl_sat[LVL_W-1:0] : hl_sat[LVL_W-1:0];
    end else if (state_r == bfmip_pkg::ST_ADD) begin
      v_r   <= quad_sum[VB+1:2];
      lvl_r <= lvl_r + LVL_W'(1);
    end
    if (emit_fire) begin
      pair_r       <= pair;
      out_level_r  <= lvl_ext[LEVW-1:0];
      out_column_r <= c_ext[PW-1:0];
      out_row_r    <= r_ext[PW-1:0];
      out_value_r  <= v_ext[TW-1:0];
      out_last_r   <= !go_up;
    end
  end

endmodule
